// ===== sv/rpb_pkg.sv =====
// rpb_pkg: types, codes and arithmetic helpers of the rgb pixel blend unit
// depends on nothing; used by the interfaces and the top level
package rpb_pkg;

    localparam int unsigned PIX_W = 32;
    localparam int unsigned WPIX_W = 24;
    localparam int unsigned CH_W = 8;
    localparam int unsigned NUM_CH = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned PIPE_DEPTH = 7;
    localparam int unsigned DIV_STAGES = 4;
    localparam logic [CH_W-1:0] CH_MAX = 8'hff;
    localparam logic [CH_W-1:0] MIX_WEIGHT_RST = 8'd128;

    typedef enum logic [3:0] {
        MODE_REPLACE  = 4'd0,
        MODE_ADD      = 4'd1,
        MODE_AVERAGE  = 4'd2,
        MODE_MULTIPLY = 4'd3,
        MODE_SCREEN   = 4'd4,
        MODE_MAX      = 4'd5,
        MODE_MIN      = 4'd6,
        MODE_DODGE    = 4'd7,
        MODE_BURN     = 4'd8,
        MODE_LINBURN  = 4'd9,
        MODE_DSUB     = 4'd10,
        MODE_SSUB     = 4'd11,
        MODE_ABSDIFF  = 4'd12,
        MODE_XOR      = 4'd13,
        MODE_WEIGHTED = 4'd14,
        MODE_BUFFER   = 4'd15
    } blend_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_MODE   = 2'd0,
        CFG_MIX_WEIGHT   = 2'd1,
        CFG_INVERT_WEIGHT = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        KIND_DIRECT,
        KIND_MUL,
        KIND_SCREEN,
        KIND_MIX,
        KIND_DODGE,
        KIND_BURN
    } chan_kind_t;

    typedef struct packed {
        logic [PIX_W-1:0]  source_pixel;
        logic [PIX_W-1:0]  dest_pixel;
        logic [WPIX_W-1:0] weight_pixel;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        chan_kind_t     kind;
        logic [CH_W-1:0] res;
        logic [15:0]    p1;
        logic [15:0]    p2;
        logic [15:0]    num;
        logic [CH_W-1:0] dv;
    } chan_prod_t;

    typedef struct packed {
        chan_prod_t [NUM_CH-1:0] ch;
        logic                    is_xor;
        logic [PIX_W-1:0]        xor_word;
        logic                    frame_end;
    } prod_stage_t;

    typedef struct packed {
        logic [CH_W-1:0] rem;
        logic [CH_W-1:0] nlo;
        logic [CH_W-1:0] q;
    } div_state_t;

    typedef struct packed {
        chan_kind_t      kind;
        logic [CH_W-1:0] res;
        logic [CH_W-1:0] dv;
        logic            ovf;
        div_state_t      ds;
    } chan_div_t;

    typedef struct packed {
        chan_div_t [NUM_CH-1:0] ch;
        logic                   is_xor;
        logic [PIX_W-1:0]       xor_word;
        logic                   frame_end;
    } div_stage_t;

    // exact floor(x / 255) for x below 65280
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [16:0] t;
        begin
            t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
            div255 = t[15:8];
        end
    endfunction

    // one restoring division step, one quotient bit
    function automatic div_state_t div_step(input div_state_t s, input logic [CH_W-1:0] dv);
        logic [CH_W:0] t;
        div_state_t    r;
        begin
            t = {s.rem, s.nlo[CH_W-1]};
            r.q = {s.q[CH_W-2:0], 1'b0};
            if (t >= {1'b0, dv})
            begin
                t = t - {1'b0, dv};
                r.q[0] = 1'b1;
            end
            r.rem = t[CH_W-1:0];
            r.nlo = {s.nlo[CH_W-2:0], 1'b0};
            div_step = r;
        end
    endfunction

endpackage

// ===== sv/rpb_in_if.sv =====
// rpb_in_if: input pixel channel of the blend unit
// depends on rpb_pkg
interface rpb_in_if;
    logic               valid;
    logic               ready;
    rpb_pkg::in_item_t  item;
    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

// ===== sv/rpb_out_if.sv =====
// rpb_out_if: blended pixel channel of the blend unit
// depends on rpb_pkg
interface rpb_out_if;
    logic                         valid;
    logic                         ready;
    logic [rpb_pkg::PIX_W-1:0]    blended_pixel;
    logic                         frame_end_out;
    modport source (output valid, output blended_pixel, output frame_end_out, input ready);
    modport sink (input valid, input blended_pixel, input frame_end_out, output ready);
endinterface

// ===== sv/rpb_cfg_if.sv =====
// rpb_cfg_if: register write channel of the blend unit
// depends on rpb_pkg
interface rpb_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [rpb_pkg::CFG_IDX_W-1:0]     index;
    logic [rpb_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/rgb_pixel_blend_unit.sv =====
// rgb_pixel_blend_unit: seven-stage pipelined 8-bit rgb blender
// depends on rpb_pkg, rpb_in_if, rpb_out_if, rpb_cfg_if
// One pixel is taken every clock while the output is not stalled; the
// depth is set by the dodge and burn divider, which resolves two quotient bits
// per stage over four stages after the multiply stage. The whole pipeline moves
// whenever its output register is empty or being taken, so a stall only holds
// items in place. Register writes are taken at once and must only be made while
// no item is in flight.
module rgb_pixel_blend_unit (
    input  logic        clk,
    input  logic        rst_n,
    rpb_in_if.sink      pix_in,
    rpb_out_if.source   pix_out,
    rpb_cfg_if.sink     cfg
);

    rpb_pkg::blend_mode_t         mode_reg;
    logic [rpb_pkg::CH_W-1:0]     weight_reg;
    logic                         inv_reg;

    logic [rpb_pkg::PIPE_DEPTH-1:0] vld_reg;
    logic                         en;

    rpb_pkg::in_item_t            st1_reg;
    rpb_pkg::prod_stage_t         st2_reg, st2_next;
    rpb_pkg::div_stage_t          div_reg [rpb_pkg::DIV_STAGES];
    rpb_pkg::div_stage_t          div_next [rpb_pkg::DIV_STAGES];
    logic [rpb_pkg::PIX_W-1:0]    out_pix_reg, out_pix_next;
    logic                         out_fe_reg;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= rpb_pkg::MODE_REPLACE;
            weight_reg <= rpb_pkg::MIX_WEIGHT_RST;
            inv_reg    <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (rpb_pkg::cfg_index_t'(cfg.index))
                rpb_pkg::CFG_BLEND_MODE:    mode_reg <= rpb_pkg::blend_mode_t'(cfg.data[3:0]);
                rpb_pkg::CFG_MIX_WEIGHT:    weight_reg <= cfg.data;
                rpb_pkg::CFG_INVERT_WEIGHT: inv_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en = !vld_reg[rpb_pkg::PIPE_DEPTH-1] || pix_out.ready;
    assign pix_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[rpb_pkg::PIPE_DEPTH-2:0], pix_in.valid};
    end

    // stage two: weight, simple results and products
    always_comb
    begin
        logic [rpb_pkg::CH_W-1:0] vmax, v, s, d, vn;
        logic [8:0]               sum;
        vmax = st1_reg.weight_pixel[7:0];
        if (st1_reg.weight_pixel[15:8] > vmax)
            vmax = st1_reg.weight_pixel[15:8];
        if (st1_reg.weight_pixel[23:16] > vmax)
            vmax = st1_reg.weight_pixel[23:16];
        if (mode_reg == rpb_pkg::MODE_BUFFER)
            v = inv_reg ? (rpb_pkg::CH_MAX - vmax) : vmax;
        else
            v = weight_reg;
        vn = rpb_pkg::CH_MAX - v;
        st2_next.is_xor    = (mode_reg == rpb_pkg::MODE_XOR);
        st2_next.xor_word  = st1_reg.source_pixel ^ st1_reg.dest_pixel;
        st2_next.frame_end = st1_reg.frame_end;
        for (int c = 0; c < rpb_pkg::NUM_CH; c++)
        begin
            s = st1_reg.source_pixel[c*8 +: 8];
            d = st1_reg.dest_pixel[c*8 +: 8];
            sum = {1'b0, s} + {1'b0, d};
            st2_next.ch[c].kind = rpb_pkg::KIND_DIRECT;
            st2_next.ch[c].res  = '0;
            st2_next.ch[c].p1   = '0;
            st2_next.ch[c].p2   = '0;
            st2_next.ch[c].num  = '0;
            st2_next.ch[c].dv   = '0;
            unique case (mode_reg)
                rpb_pkg::MODE_REPLACE:  st2_next.ch[c].res = s;
                rpb_pkg::MODE_ADD:      st2_next.ch[c].res = sum[8] ? rpb_pkg::CH_MAX : sum[7:0];
                rpb_pkg::MODE_AVERAGE:  st2_next.ch[c].res = {1'b0, s[7:1]} + {1'b0, d[7:1]};
                rpb_pkg::MODE_MULTIPLY:
                begin
                    st2_next.ch[c].kind = rpb_pkg::KIND_MUL;
                    st2_next.ch[c].p1   = 16'(s) * 16'(d);
                end
                rpb_pkg::MODE_SCREEN:
                begin
                    st2_next.ch[c].kind = rpb_pkg::KIND_SCREEN;
                    st2_next.ch[c].p2   = 16'(rpb_pkg::CH_MAX - s) * 16'(rpb_pkg::CH_MAX - d);
                end
                rpb_pkg::MODE_MAX:      st2_next.ch[c].res = (s > d) ? s : d;
                rpb_pkg::MODE_MIN:      st2_next.ch[c].res = (s < d) ? s : d;
                rpb_pkg::MODE_DODGE:
                begin
                    if (s == '0)
                        st2_next.ch[c].res = '0;
                    else if (d == rpb_pkg::CH_MAX)
                        st2_next.ch[c].res = rpb_pkg::CH_MAX;
                    else
                    begin
                        st2_next.ch[c].kind = rpb_pkg::KIND_DODGE;
                        st2_next.ch[c].num  = {s, 8'h00} - {8'h00, s};
                        st2_next.ch[c].dv   = rpb_pkg::CH_MAX - d;
                    end
                end
                rpb_pkg::MODE_BURN:
                begin
                    if (s == rpb_pkg::CH_MAX)
                        st2_next.ch[c].res = rpb_pkg::CH_MAX;
                    else if (d == '0)
                        st2_next.ch[c].res = '0;
                    else
                    begin
                        st2_next.ch[c].kind = rpb_pkg::KIND_BURN;
                        st2_next.ch[c].num  = {rpb_pkg::CH_MAX - s, 8'h00}
                                            - {8'h00, rpb_pkg::CH_MAX - s};
                        st2_next.ch[c].dv   = d;
                    end
                end
                rpb_pkg::MODE_LINBURN:  st2_next.ch[c].res = sum[8] ? (sum[7:0] + 8'd1) : '0;
                rpb_pkg::MODE_DSUB:     st2_next.ch[c].res = (d > s) ? (d - s) : '0;
                rpb_pkg::MODE_SSUB:     st2_next.ch[c].res = (s > d) ? (s - d) : '0;
                rpb_pkg::MODE_ABSDIFF:  st2_next.ch[c].res = (d > s) ? (d - s) : (s - d);
                rpb_pkg::MODE_XOR:      st2_next.ch[c].res = '0;
                rpb_pkg::MODE_WEIGHTED,
                rpb_pkg::MODE_BUFFER:
                begin
                    st2_next.ch[c].kind = rpb_pkg::KIND_MIX;
                    st2_next.ch[c].p1   = 16'(s) * 16'(v);
                    st2_next.ch[c].p2   = 16'(d) * 16'(vn);
                end
            endcase
        end
    end

    // stage three: scaling by 1/255, overflow check, first quotient bits
    // stages four to six: two quotient bits each
    always_comb
    begin
        logic [rpb_pkg::CH_W-1:0] q1, q2;
        rpb_pkg::div_state_t      ds;
        div_next[0].is_xor    = st2_reg.is_xor;
        div_next[0].xor_word  = st2_reg.xor_word;
        div_next[0].frame_end = st2_reg.frame_end;
        for (int c = 0; c < rpb_pkg::NUM_CH; c++)
        begin
            q1 = rpb_pkg::div255(st2_reg.ch[c].p1);
            q2 = rpb_pkg::div255(st2_reg.ch[c].p2);
            div_next[0].ch[c].kind = st2_reg.ch[c].kind;
            div_next[0].ch[c].dv   = st2_reg.ch[c].dv;
            unique case (st2_reg.ch[c].kind)
                rpb_pkg::KIND_MUL:    div_next[0].ch[c].res = q1;
                rpb_pkg::KIND_SCREEN: div_next[0].ch[c].res = rpb_pkg::CH_MAX - q2;
                rpb_pkg::KIND_MIX:    div_next[0].ch[c].res = q1 + q2;
                default:              div_next[0].ch[c].res = st2_reg.ch[c].res;
            endcase
            div_next[0].ch[c].ovf = (st2_reg.ch[c].num >= {st2_reg.ch[c].dv, 8'h00});
            ds.rem = st2_reg.ch[c].num[15:8];
            ds.nlo = st2_reg.ch[c].num[7:0];
            ds.q   = '0;
            ds = rpb_pkg::div_step(ds, st2_reg.ch[c].dv);
            div_next[0].ch[c].ds = rpb_pkg::div_step(ds, st2_reg.ch[c].dv);
        end
        for (int k = 1; k < rpb_pkg::DIV_STAGES; k++)
        begin
            div_next[k] = div_reg[k-1];
            for (int c = 0; c < rpb_pkg::NUM_CH; c++)
                div_next[k].ch[c].ds = rpb_pkg::div_step(
                    rpb_pkg::div_step(div_reg[k-1].ch[c].ds, div_reg[k-1].ch[c].dv),
                    div_reg[k-1].ch[c].dv);
        end
    end

    // output stage: clamp and assemble
    always_comb
    begin
        logic [rpb_pkg::CH_W-1:0] qc;
        out_pix_next = '0;
        for (int c = 0; c < rpb_pkg::NUM_CH; c++)
        begin
            qc = div_reg[rpb_pkg::DIV_STAGES-1].ch[c].ovf ? rpb_pkg::CH_MAX
                                                          : div_reg[rpb_pkg::DIV_STAGES-1].ch[c].ds.q;
            unique case (div_reg[rpb_pkg::DIV_STAGES-1].ch[c].kind)
                rpb_pkg::KIND_DODGE: out_pix_next[c*8 +: 8] = qc;
                rpb_pkg::KIND_BURN:  out_pix_next[c*8 +: 8] = rpb_pkg::CH_MAX - qc;
                default:             out_pix_next[c*8 +: 8] = div_reg[rpb_pkg::DIV_STAGES-1].ch[c].res;
            endcase
        end
        if (div_reg[rpb_pkg::DIV_STAGES-1].is_xor)
            out_pix_next = div_reg[rpb_pkg::DIV_STAGES-1].xor_word;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_reg     <= pix_in.item;
            st2_reg     <= st2_next;
            for (int k = 0; k < rpb_pkg::DIV_STAGES; k++)
                div_reg[k] <= div_next[k];
            out_pix_reg <= out_pix_next;
            out_fe_reg  <= div_reg[rpb_pkg::DIV_STAGES-1].frame_end;
        end
    end

    assign pix_out.valid         = vld_reg[rpb_pkg::PIPE_DEPTH-1];
    assign pix_out.blended_pixel = out_pix_reg;
    assign pix_out.frame_end_out = out_fe_reg;

    a_top_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && mode_reg != rpb_pkg::MODE_XOR |-> pix_out.blended_pixel[31:24] == '0)
        else $error("top byte set outside xor mode");

    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.ready == (!pix_out.valid || pix_out.ready))
        else $error("input ready does not track output stage");

    a_bubble_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en && !vld_reg[rpb_pkg::PIPE_DEPTH-2] |=> !pix_out.valid)
        else $error("bubble did not reach output");

    a_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== tb/rgb_pixel_blend_unit_tb.sv =====
// rgb_pixel_blend_unit_tb: self-checking bench for the rgb pixel blend unit
// depends on rpb_pkg, rpb_in_if, rpb_out_if, rpb_cfg_if and the top level
// drives directed and random pixels over every mode and checks each blended item
`timescale 1ns / 1ps

module rgb_pixel_blend_unit_tb;

    typedef struct {
        logic [rpb_pkg::PIX_W-1:0] pixel;
        logic                      fend;
    } blend_result_t;

    class blend_scoreboard;
        rpb_pkg::blend_mode_t     mode;
        logic [rpb_pkg::CH_W-1:0] weight;
        logic                     invert;
        blend_result_t            pending[$];
        int                       errors;

        function new();
            mode = rpb_pkg::MODE_REPLACE;
            weight = rpb_pkg::MIX_WEIGHT_RST;
            invert = 1'b0;
            errors = 0;
        endfunction

        function int scale255(int a, int b);
            return (a * b) / 255;
        endfunction

        function int blend_channel(int s, int d, int v);
            int t;
            unique case (mode)
                rpb_pkg::MODE_REPLACE:  return s;
                rpb_pkg::MODE_ADD:      return (s + d > 255) ? 255 : s + d;
                rpb_pkg::MODE_AVERAGE:  return (s >> 1) + (d >> 1);
                rpb_pkg::MODE_MULTIPLY: return scale255(s, d);
                rpb_pkg::MODE_SCREEN:   return 255 - scale255(255 - s, 255 - d);
                rpb_pkg::MODE_MAX:      return (s > d) ? s : d;
                rpb_pkg::MODE_MIN:      return (s < d) ? s : d;
                rpb_pkg::MODE_DODGE:
                begin
                    if (s == 0) return 0;
                    if (d == 255) return 255;
                    t = (s * 255) / (255 - d);
                    return (t > 255) ? 255 : t;
                end
                rpb_pkg::MODE_BURN:
                begin
                    if (s == 255) return 255;
                    if (d == 0) return 0;
                    t = ((255 - s) * 255) / d;
                    return 255 - ((t > 255) ? 255 : t);
                end
                rpb_pkg::MODE_LINBURN:  return (s + d > 255) ? s + d - 255 : 0;
                rpb_pkg::MODE_DSUB:     return (d > s) ? d - s : 0;
                rpb_pkg::MODE_SSUB:     return (s > d) ? s - d : 0;
                rpb_pkg::MODE_ABSDIFF:  return (d > s) ? d - s : s - d;
                default:                return scale255(s, v) + scale255(d, 255 - v);
            endcase
        endfunction

        function void note_pixel(rpb_pkg::in_item_t it);
            blend_result_t r;
            int v;
            int c;
            v = weight;
            if (mode == rpb_pkg::MODE_BUFFER)
            begin
                v = it.weight_pixel[23:16];
                if (it.weight_pixel[15:8] > v) v = it.weight_pixel[15:8];
                if (it.weight_pixel[7:0] > v) v = it.weight_pixel[7:0];
                if (invert) v = 255 - v;
            end
            r.pixel = '0;
            if (mode == rpb_pkg::MODE_XOR)
                r.pixel = it.source_pixel ^ it.dest_pixel;
            else
                for (c = 0; c < rpb_pkg::NUM_CH; c++)
                    r.pixel[c*8 +: 8] = 8'(blend_channel(it.source_pixel[c*8 +: 8],
                                                         it.dest_pixel[c*8 +: 8], v));
            r.fend = it.frame_end;
            pending.push_back(r);
        endfunction

        task report(string what, logic [rpb_pkg::PIX_W-1:0] got,
                    logic [rpb_pkg::PIX_W-1:0] want);
            $display("error %s: got %h expected %h at %0t", what, got, want, $time);
            errors++;
        endtask

        task check_pixel(logic [rpb_pkg::PIX_W-1:0] px, logic fe);
            blend_result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected item", px, '0);
                return;
            end
            w = pending.pop_front();
            if (px !== w.pixel) report("blended_pixel", px, w.pixel);
            if (fe !== w.fend) report("frame_end_out", 32'(fe), 32'(w.fend));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   idle_pct;
    blend_scoreboard sb;

    rpb_in_if  pix_in ();
    rpb_out_if pix_out ();
    rpb_cfg_if cfg ();

    rgb_pixel_blend_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in.sink),
        .pix_out (pix_out.source),
        .cfg     (cfg.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sink side: random stalls and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_out.valid && pix_out.ready)
                sb.check_pixel(pix_out.blended_pixel, pix_out.frame_end_out);
            pix_out.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task write_reg(rpb_pkg::cfg_index_t idx, logic [rpb_pkg::CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        unique case (idx)
            rpb_pkg::CFG_BLEND_MODE:    sb.mode = rpb_pkg::blend_mode_t'(val[3:0]);
            rpb_pkg::CFG_MIX_WEIGHT:    sb.weight = val;
            rpb_pkg::CFG_INVERT_WEIGHT: sb.invert = val[0];
            default: ;
        endcase
    endtask

    task drain;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task send_pixel(logic [31:0] s, logic [31:0] d, logic [23:0] w, logic fe);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid <= 1'b1;
        pix_in.item <= '{source_pixel: s, dest_pixel: d, weight_pixel: w, frame_end: fe};
        do @(posedge clk); while (!pix_in.ready);
        sb.note_pixel(pix_in.item);
    endtask

    task stop_pixels;
        pix_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    task send_random;
        logic [31:0] s;
        logic [31:0] d;
        s = $urandom;
        d = $urandom;
        case ($urandom_range(5))
            0: s[7:0] = 8'h00;
            1: s[15:8] = 8'hff;
            2: d[7:0] = 8'hff;
            3: d[23:16] = 8'h00;
            default: ;
        endcase
        send_pixel(s, d, 24'($urandom), 1'($urandom));
    endtask

    task directed_set;
        send_pixel(32'h00000000, 32'h00000000, 24'h000000, 1'b0);
        send_pixel(32'hffffffff, 32'hffffffff, 24'hffffff, 1'b1);
        send_pixel(32'hff00ff00, 32'h00ff00ff, 24'h00ff00, 1'b0);
        send_pixel(32'h12ff0080, 32'hab00ff7f, 24'h7f0001, 1'b1);
        send_pixel(32'h00fe01ff, 32'hff01fe00, 24'h800080, 1'b0);
        stop_pixels();
    endtask

    initial
    begin
        int m;
        int k;
        sb = new();
        idle_pct = 38;
        rst_n = 1'b0;
        pix_in.valid = 1'b0;
        pix_in.item = '0;
        pix_out.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = rpb_pkg::CFG_BLEND_MODE;
        cfg.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first
        directed_set();
        drain();

        for (m = 0; m < 16; m++)
        begin
            write_reg(rpb_pkg::CFG_BLEND_MODE, 8'(m));
            write_reg(rpb_pkg::CFG_MIX_WEIGHT, (m == 14) ? 8'hff : 8'h00);
            write_reg(rpb_pkg::CFG_INVERT_WEIGHT, 8'h01);
            directed_set();
            drain();
        end

        for (k = 0; k < 20; k++)
        begin
            idle_pct = (k == 3 || k == 4) ? 0 : 38;
            write_reg(rpb_pkg::CFG_BLEND_MODE, 8'($urandom_range(15)));
            write_reg(rpb_pkg::CFG_MIX_WEIGHT,
                      (k % 5 == 0) ? 8'h00 : (k % 5 == 1) ? 8'hff : 8'($urandom));
            write_reg(rpb_pkg::CFG_INVERT_WEIGHT, 8'($urandom_range(1)));
            repeat (21) send_random();
            stop_pixels();
            drain();
        end
        idle_pct = 38;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== files.f =====
sv/rpb_pkg.sv
sv/rpb_in_if.sv
sv/rpb_out_if.sv
sv/rpb_cfg_if.sv
sv/rgb_pixel_blend_unit.sv
tb/rgb_pixel_blend_unit_tb.sv
